// ----- rtl/fmrt_pkg.sv -----
package fmrt_pkg;

	localparam int CAL_W       = 16;
	localparam int SS_W        = 12;
	localparam int ELAPSED_W   = 16;
	localparam int COUNT_W     = 16;
	localparam int RATE_W      = 32;
	localparam int TOTAL_W     = 32;
	localparam int SCALE_W     = 24;
	localparam int NUM_W       = SCALE_W + COUNT_W;
	localparam int DEN_W       = ELAPSED_W + CAL_W;
	localparam int VPROD_W     = RATE_W + SS_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Rate in hundredths of l/min = 1e7 * pulses / (elapsed_ms * cal_x100).
	localparam logic [SCALE_W-1:0] RATE_SCALE = 24'd10000000;

	localparam logic [CAL_W-1:0]   CAL_RESET = 16'd750;
	localparam logic [SS_W-1:0]    SS_RESET  = 12'd1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_CAL0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SS   = 2'd2;

endpackage

// ----- rtl/flow_meter_rate_totalizer_unit.sv -----
// Two-channel flow meter. A pulse transaction (s_tuser[0] = 0) bumps the
// pulse count of its channel, saturating at 65535. A measure transaction
// (s_tuser[0] = 1) takes and clears the count and reports
// rate = 1e7 * pulses / (elapsed_ms * cal) in hundredths of l/min and the
// channel total, which grows by sampling_seconds * rate / 6 ml on a nonzero
// rate and is cleared on a zero rate. A measure with no counted pulses
// goes straight to the total update; any other measure runs the bit-serial
// path: the two multiplies, which run side by side, the one-bit-per-cycle
// rate divider (which saturates without iterating when the quotient would
// overflow), the volume multiply and the base-4 divide by six, then the
// total update, which returns to idle before the next transaction. A rate
// that truncates to zero skips the volume path. Only one measure is in
// flight; s_tready is low meanwhile, while a finished result may wait on
// the output register.
// Configuration writes are taken at any time but belong in idle periods.
module flow_meter_rate_totalizer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [fmrt_pkg::ELAPSED_W-1:0]     s_tdata,   // elapsed_ms
	input  logic [1:0]                         s_tuser,   // action, channel
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [fmrt_pkg::RATE_W+fmrt_pkg::TOTAL_W-1:0] m_tdata, // rate_centi_lpm, total_ml
	output logic                               m_tuser,   // channel_out
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fmrt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fmrt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import fmrt_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_VMUL  = 3'd3;
	localparam logic [2:0] ST_VDIV  = 3'd4;
	localparam logic [2:0] ST_TOTAL = 3'd5;

	logic [2:0]           state_q;
	logic [CAL_W-1:0]     cal_q [2];
	logic [SS_W-1:0]      ss_q;
	logic [COUNT_W-1:0]   pulse_cnt_q [2];
	logic [TOTAL_W-1:0]   total_q [2];
	logic                 ch_q;
	logic [RATE_W-1:0]    rate_q;
	logic [TOTAL_W-1:0]   vol_q;
	logic                 m_tvalid_q;
	logic [RATE_W+TOTAL_W-1:0] m_tdata_q;
	logic                 m_tuser_q;

	logic                 in_action;
	logic                 in_ch;
	logic                 accept;
	logic [COUNT_W-1:0]   cur_pulses;
	logic                 mul_start;
	logic                 den_done;
	logic                 num_done;
	logic [DEN_W-1:0]     den_prod;
	logic [NUM_W-1:0]     num_prod;
	logic                 div_start;
	logic                 div_done;
	logic [RATE_W-1:0]    div_quot;
	logic                 vmul_start;
	logic                 vmul_done;
	logic [VPROD_W-1:0]   vmul_prod;
	logic                 d6_start;
	logic                 d6_done;
	logic [VPROD_W-1:0]   d6_quot;
	logic                 out_free;
	logic                 load_out;
	logic [TOTAL_W:0]     total_sum;
	logic [TOTAL_W-1:0]   new_total;

	assign in_action  = s_tuser[0];
	assign in_ch      = s_tuser[1];
	assign s_tready   = state_q == ST_IDLE;
	assign accept     = s_tvalid & s_tready;
	assign cur_pulses = pulse_cnt_q[in_ch];
	assign cfg_ready  = 1'b1;

	assign mul_start  = accept & in_action & (cur_pulses != '0);
	assign div_start  = (state_q == ST_MUL) & den_done & num_done;
	assign vmul_start = (state_q == ST_DIV) & div_done & (div_quot != '0);
	assign d6_start   = (state_q == ST_VMUL) & vmul_done;

	fmrt_smul #(.AW(CAL_W), .BW(ELAPSED_W)) u_den_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(cal_q[in_ch]), .b(s_tdata), .done(den_done), .product(den_prod)
	);

	fmrt_smul #(.AW(SCALE_W), .BW(COUNT_W)) u_num_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(RATE_SCALE), .b(cur_pulses), .done(num_done), .product(num_prod)
	);

	fmrt_sdiv #(.NW(NUM_W), .DW(DEN_W), .QW(RATE_W)) u_rate_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_prod), .den(den_prod), .done(div_done), .quot(div_quot)
	);

	fmrt_smul #(.AW(RATE_W), .BW(SS_W)) u_vol_mul (
		.clk(clk), .arst_n(arst_n), .start(vmul_start),
		.a(div_quot), .b(ss_q), .done(vmul_done), .product(vmul_prod)
	);

	fmrt_div6 #(.W(VPROD_W)) u_vol_div (
		.clk(clk), .arst_n(arst_n), .start(d6_start),
		.value(vmul_prod), .done(d6_done), .quot(d6_quot)
	);

	assign out_free  = !m_tvalid_q | m_tready;
	assign load_out  = (state_q == ST_TOTAL) & out_free;
	assign total_sum = {1'b0, total_q[ch_q]} + {1'b0, vol_q};

	always_comb begin
		if (rate_q == '0) begin
			new_total = '0;
		end else if (total_sum[TOTAL_W]) begin
			new_total = '1;
		end else begin
			new_total = total_sum[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cal_q[0]       <= CAL_RESET;
			cal_q[1]       <= CAL_RESET;
			ss_q           <= SS_RESET;
			pulse_cnt_q[0] <= '0;
			pulse_cnt_q[1] <= '0;
			total_q[0]     <= '0;
			total_q[1]     <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CAL0: cal_q[0] <= cfg_data[CAL_W-1:0];
					REG_CAL1: cal_q[1] <= cfg_data[CAL_W-1:0];
					REG_SS:   ss_q     <= cfg_data[SS_W-1:0];
					default: begin
					end
				endcase
			end

			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_action) begin
							pulse_cnt_q[in_ch] <= '0;
							state_q <= (cur_pulses == '0) ? ST_TOTAL : ST_MUL;
						end else if (cur_pulses != COUNT_MAX) begin
							pulse_cnt_q[in_ch] <= cur_pulses + 1'b1;
						end
					end
				end
				ST_MUL: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= (div_quot != '0) ? ST_VMUL : ST_TOTAL;
					end
				end
				ST_VMUL: begin
					if (vmul_done) begin
						state_q <= ST_VDIV;
					end
				end
				ST_VDIV: begin
					if (d6_done) begin
						state_q <= ST_TOTAL;
					end
				end
				ST_TOTAL: begin
					if (out_free) begin
						total_q[ch_q] <= new_total;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_action) begin
			ch_q   <= in_ch;
			rate_q <= '0;
		end
		if ((state_q == ST_DIV) && div_done) begin
			rate_q <= div_quot;
		end
		if ((state_q == ST_VDIV) && d6_done) begin
			vol_q <= (d6_quot[VPROD_W-1:TOTAL_W] != '0) ? '1 : d6_quot[TOTAL_W-1:0];
		end
		if (load_out) begin
			m_tdata_q <= {new_total, rate_q};
			m_tuser_q <= ch_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_pulse_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_action && !m_tvalid_q |=> !m_tvalid_q)
		else $error("pulse transaction produced a result");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("rate divider finished outside its state");

	a_zero_rate_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && rate_q == '0 |=> m_tdata_q[RATE_W +: TOTAL_W] == '0)
		else $error("zero rate did not clear the total");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_action && cur_pulses == COUNT_MAX
		|=> pulse_cnt_q[$past(in_ch)] == COUNT_MAX)
		else $error("pulse count wrapped");

endmodule

// ----- rtl/fmrt_smul.sv -----
module fmrt_smul #(
	parameter int AW = fmrt_pkg::CAL_W,
	parameter int BW = fmrt_pkg::ELAPSED_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] product
);

	localparam int PW = AW + BW;
	localparam int CW = $clog2(BW + 1);

	logic [PW-1:0] acc_q;
	logic [PW-1:0] mcand_q;
	logic [BW-1:0] mplier_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(BW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// One multiplier bit per cycle, least significant first.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= PW'(a);
			mplier_q <= b;
		end else if (cnt_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[BW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- rtl/fmrt_sdiv.sv -----
module fmrt_sdiv #(
	parameter int NW = fmrt_pkg::NUM_W,
	parameter int DW = fmrt_pkg::DEN_W,
	parameter int QW = fmrt_pkg::RATE_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quot
);

	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] low_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic          ovf;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	// The quotient fits in QW bits exactly when the numerator's upper part is
	// below the divisor; otherwise the result saturates without iterating.
	assign ovf   = DW'(num[NW-1:QW]) >= den;
	assign trial = {rem_q, low_q[QW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (ovf) begin
					done_q <= 1'b1;
				end else begin
					cnt_q <= CW'(QW);
				end
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division: quotient bits shift in as numerator bits shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= DW'(num[NW-1:QW]);
			low_q <= ovf ? '1 : num[QW-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			low_q <= {low_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = low_q;

endmodule

// ----- rtl/fmrt_div6.sv -----
module fmrt_div6 #(
	parameter int W = fmrt_pkg::VPROD_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] value,
	output logic         done,
	output logic [W-1:0] quot
);

	localparam int SW = W / 2;
	localparam int CW = $clog2(SW + 1);

	logic [W-1:0]  val_q;
	logic [2:0]    rem_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [4:0]    part;
	logic [1:0]    qd;
	logic [4:0]    sub;
	logic [4:0]    rest;

	// One base-4 digit per cycle; the running remainder stays below six.
	assign part = {rem_q, val_q[W-1:W-2]};

	always_comb begin
		priority if (part >= 5'd18) begin
			qd  = 2'd3;
			sub = 5'd18;
		end else if (part >= 5'd12) begin
			qd  = 2'd2;
			sub = 5'd12;
		end else if (part >= 5'd6) begin
			qd  = 2'd1;
			sub = 5'd6;
		end else begin
			qd  = 2'd0;
			sub = 5'd0;
		end
	end

	assign rest = part - sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(SW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			val_q <= {val_q[W-3:0], qd};
			rem_q <= rest[2:0];
		end
	end

	assign done = done_q;
	assign quot = val_q;

endmodule
